>>> rtl/ncdf_pkg.sv
// Package for the normal CDF block: fixed-point constants, pipeline stage
// record and the Taylor reciprocal table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ncdf_pkg;

  localparam longint unsigned Q_SCALE = 64'd16777216;
  localparam logic signed [31:0] ONE_Q = 32'sd16777216;

  localparam logic signed [31:0] B1_Q =
    32'((64'd319381530 * Q_SCALE + 64'd500000000) / 64'd1000000000);
  localparam logic signed [31:0] B2_Q =
    -32'((64'd356563782 * Q_SCALE + 64'd500000000) / 64'd1000000000);
  localparam logic signed [31:0] B3_Q =
    32'((64'd1781477937 * Q_SCALE + 64'd500000000) / 64'd1000000000);
  localparam logic signed [31:0] B4_Q =
    -32'((64'd1821255978 * Q_SCALE + 64'd500000000) / 64'd1000000000);
  localparam logic signed [31:0] B5_Q =
    32'((64'd1330274429 * Q_SCALE + 64'd500000000) / 64'd1000000000);
  localparam logic [39:0] P_Q =
    40'((64'd2316419 * Q_SCALE + 64'd5000000) / 64'd10000000);
  localparam logic signed [31:0] C_Q =
    32'((64'd39894228 * Q_SCALE + 64'd50000000) / 64'd100000000);
  localparam logic signed [31:0] LOG2E_Q =
    32'((64'd1442695041 * Q_SCALE + 64'd500000000) / 64'd1000000000);
  localparam logic signed [31:0] LN2_Q =
    32'((64'd693147181 * Q_SCALE + 64'd500000000) / 64'd1000000000);

  localparam int NSTG = 35;

  typedef struct packed {
    logic               vld;
    logic               neg;
    logic [16:0]        a;
    logic [30:0]        aa;
    logic [25:0]        d;
    logic [25:0]        rem;
    logic [24:0]        q;
    logic [5:0]         n;
    logic signed [31:0] r;
    logic signed [31:0] e;
    logic signed [31:0] m;
    logic signed [31:0] cx;
    logic signed [31:0] acc;
    logic [24:0]        cdf;
    logic [24:0]        tail;
  } stage_t;

  // round(1/k) in Q.24
  function automatic logic signed [31:0] inv_coef(input logic [3:0] k);
    logic signed [31:0] v;
    case (k)
      4'd1:    v = 32'sd16777216;
      4'd2:    v = 32'sd8388608;
      4'd3:    v = 32'sd5592405;
      4'd4:    v = 32'sd4194304;
      4'd5:    v = 32'sd3355443;
      4'd6:    v = 32'sd2796203;
      4'd7:    v = 32'sd2396745;
      4'd8:    v = 32'sd2097152;
      4'd9:    v = 32'sd1864135;
      4'd10:   v = 32'sd1677722;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/normal_cdf_approximation.sv
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat is stalled.
// Stages: square and scale, 25 restoring reciprocal steps alongside the
// range-reduced exp (20 Taylor multiply stages), Horner polynomial, clamp.
// Reset: synchronous, active low; clears the valid bits of every stage.
`timescale 1ns / 1ps
`default_nettype none
module normal_cdf_approximation
  import ncdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] x_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // [24:0] cdf_value, [49:25] tail_value, zero pad
);

  function automatic logic signed [31:0] mulq(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [63:0] p;
    logic [63:0]        mag;
    logic [63:0]        rr;
    p   = 64'(x) * 64'(y);
    mag = p[63] ? 64'(-p) : 64'(p);
    rr  = (mag + (64'd1 << 23)) >> 24;
    return p[63] ? -$signed(rr[31:0]) : $signed(rr[31:0]);
  endfunction

  function automatic stage_t step(input int k, input stage_t s);
    stage_t             o;
    logic [39:0]        ap;
    logic [31:0]        aa1;
    logic signed [31:0] w;
    logic [26:0]        rs;
    logic signed [31:0] t;
    logic [32:0]        eu;
    logic signed [31:0] tc;
    int                 j;
    int                 bi;
    o   = s;
    t   = $signed({7'd0, s.q});
    j   = k - 5;
    bi  = 28 - k;
    if (k == 2) begin
      ap   = 40'(s.a) * P_Q;
      o.d  = 26'(40'(ONE_Q) + ((ap + 40'd2048) >> 12));
      aa1  = 32'(s.aa) + 32'd1;
      o.aa = 31'(aa1[31:1]);
    end else if (k == 3) begin
      w     = mulq($signed({1'b0, s.aa}), LOG2E_Q);
      o.n   = w[29:24];
      o.r   = $signed({8'd0, w[23:0]});
      o.rem = 26'd1 << 23;
      o.q   = '0;
    end
    if (k >= 4 && k <= 28) begin
      rs = {s.rem, s.d[bi + 1]};
      if (rs >= {1'b0, s.d}) begin
        o.rem   = 26'(rs - {1'b0, s.d});
        o.q[bi] = 1'b1;
      end else begin
        o.rem = rs[25:0];
      end
    end
    if (k == 4) begin
      o.r = mulq(s.r, LN2_Q);
      o.e = ONE_Q;
    end else if (k >= 5 && k <= 24) begin
      if ((j & 1) == 0) begin
        o.m = mulq(s.r, s.e);
      end else begin
        o.e = ONE_Q - mulq(s.m, inv_coef(4'(10 - (j >> 1))));
      end
    end else if (k == 25) begin
      eu = {1'b0, s.e};
      if (s.n == 6'd0) begin
        o.e = s.e;
      end else if (s.n > 6'd25) begin
        o.e = '0;
      end else begin
        eu  = (eu + (33'd1 << (s.n - 6'd1))) >> s.n;
        o.e = $signed(eu[31:0]);
      end
    end else if (k == 26) begin
      o.cx = mulq(C_Q, s.e);
    end
    if (k == 29) begin
      o.acc = mulq(B5_Q, t) + B4_Q;
    end else if (k == 30) begin
      o.acc = mulq(s.acc, t) + B3_Q;
    end else if (k == 31) begin
      o.acc = mulq(s.acc, t) + B2_Q;
    end else if (k == 32) begin
      o.acc = mulq(s.acc, t) + B1_Q;
    end else if (k == 33) begin
      o.acc = mulq(s.acc, t);
    end else if (k == 34) begin
      o.acc = mulq(s.cx, s.acc);
    end else if (k == 35) begin
      if (s.acc < 0) begin
        tc = '0;
      end else if (s.acc > ONE_Q) begin
        tc = ONE_Q;
      end else begin
        tc = s.acc;
      end
      if (s.neg) begin
        o.cdf  = tc[24:0];
        o.tail = 25'(ONE_Q - tc);
      end else begin
        o.cdf  = 25'(ONE_Q - tc);
        o.tail = tc[24:0];
      end
    end
    return o;
  endfunction

  stage_t      pipe_r [1:NSTG];
  stage_t      pipe_nxt [1:NSTG];
  stage_t      s_in;
  logic        en;
  logic [16:0] a_in;

  assign en        = !pipe_r[NSTG].vld || out_tready;
  assign in_tready = en;
  assign a_in      = in_tdata[15] ? 17'(18'h10000 - 18'(in_tdata)) : {1'b0, in_tdata};

  always_comb begin
    s_in     = '0;
    s_in.vld = in_tvalid;
    s_in.neg = in_tdata[15];
    s_in.a   = a_in;
    s_in.aa  = 31'(34'(a_in) * 34'(a_in));
  end

  assign pipe_nxt[1] = s_in;

  for (genvar g = 2; g <= NSTG; g++) begin : g_stage
    assign pipe_nxt[g] = step(g, pipe_r[g - 1]);
  end

  for (genvar g = 1; g <= NSTG; g++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[g].vld <= 1'b0;
      end else if (en) begin
        pipe_r[g] <= pipe_nxt[g];
      end
    end
  end

  assign out_tvalid = pipe_r[NSTG].vld;
  assign out_tdata  = {6'd0, pipe_r[NSTG].tail, pipe_r[NSTG].cdf};

  a_sum_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (26'(pipe_r[NSTG].cdf) + 26'(pipe_r[NSTG].tail) == 26'(ONE_Q)))
    else $error("cdf and tail do not sum to one");

  a_cdf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pipe_r[NSTG].cdf <= 25'(ONE_Q)))
    else $error("cdf above one");

  a_recip_range: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_r[28].vld |-> (pipe_r[28].q <= 25'(ONE_Q)))
    else $error("reciprocal above one");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_r[25].vld |-> (pipe_r[25].e >= 0 && pipe_r[25].e <= ONE_Q))
    else $error("exponential out of range");

endmodule
`default_nettype wire
